// File: rtl/ssed_pkg.sv
// ----------------------------------------------------------------------------
// Song event stream decoder package
// Types, codes and widths shared by the front parser, the command queue and
// the back end of the song event stream decoder.
// ----------------------------------------------------------------------------
package ssed_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned MsW      = 11;
  localparam int unsigned FpmsW    = 24;
  localparam int unsigned ProdW    = MsW + FpmsW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned FramesW  = 20;
  localparam int unsigned OffsetW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned CmdDepth = 4;

  localparam logic [FpmsW-1:0]   FpmsReset   = 24'd2890138;
  localparam logic [OffsetW-1:0] OffsetReset = 16'd0;

  localparam logic [3:0] LeadTimedNote = 4'h8;
  localparam logic [3:0] LeadFireNote  = 4'h9;
  localparam logic [4:0] LeadWheel     = 5'b10100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_RATE    = 2'd0,
    CFG_REPEAT_ENABLE = 2'd1,
    CFG_LOOP_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_DELAY  = 3'd0,
    KIND_TIMED  = 3'd1,
    KIND_FIRE   = 3'd2,
    KIND_WHEEL  = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef struct packed {
    logic             evt_valid;
    kind_e            kind;
    logic [ChanW-1:0] channel;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  velocity;
    logic [ByteW-1:0] wheel;
    logic [MsW-1:0]   ms;
    logic             end_flag;
  } cmd_t;

  typedef struct packed {
    logic [FpmsW-1:0]   frame_rate;
    logic               repeat_enable;
    logic [OffsetW-1:0] loop_offset;
  } cfg_t;

endpackage

// File: rtl/song_event_stream_decoder.sv
// ----------------------------------------------------------------------------
// Song event stream decoder
// Decodes a compact song byte stream into delay, note, wheel and end events.
// ----------------------------------------------------------------------------
// The decoder takes one song byte per clock cycle while full is low and
// presents results in order while empty is low. A byte that completes an
// event passes from the command queue through the duration multiplier
// register into the output register, where it waits until popped. The
// output register hands over one result per cycle while pop is high, so a
// byte that causes an event and an end result holds it until both are
// popped; the command queue of CmdDepth entries absorbs that while the
// input keeps flowing. Configuration writes are always taken and
// should be made while no item is in flight.
module song_event_stream_decoder #(
  parameter int unsigned CmdDepth = ssed_pkg::CmdDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [ssed_pkg::ByteW-1:0]      song_byte_i,
  input  logic                            start_of_pass_i,
  input  logic                            final_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      event_kind_o,
  output logic [ssed_pkg::ChanW-1:0]      channel_o,
  output logic [ssed_pkg::NoteW-1:0]      note_number_o,
  output logic [ssed_pkg::VelW-1:0]       velocity_o,
  output logic [ssed_pkg::ByteW-1:0]      wheel_value_o,
  output logic [ssed_pkg::FramesW-1:0]    frames_o,
  output logic                            restart_o,
  output logic [ssed_pkg::OffsetW-1:0]    restart_offset_o,
  output logic                            last_of_run_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssed_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssed_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CmdW = $bits(ssed_pkg::cmd_t);

  ssed_pkg::cfg_t  cfg_q;
  ssed_pkg::cmd_t  front_cmd, queue_cmd;
  logic [CmdW-1:0] queue_data;
  logic            front_push, queue_empty, queue_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_rate    <= ssed_pkg::FpmsReset;
      cfg_q.repeat_enable <= 1'b0;
      cfg_q.loop_offset   <= ssed_pkg::OffsetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ssed_pkg::CFG_FRAME_RATE:    cfg_q.frame_rate <= cfg_data_i;
        ssed_pkg::CFG_REPEAT_ENABLE: cfg_q.repeat_enable <= cfg_data_i[0];
        ssed_pkg::CFG_LOOP_OFFSET:   cfg_q.loop_offset <= cfg_data_i[ssed_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  ssed_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .song_byte_i     (song_byte_i),
    .start_of_pass_i (start_of_pass_i),
    .final_byte_i    (final_byte_i),
    .cmd_push_o      (front_push),
    .cmd_o           (front_cmd)
  );

  ssed_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .data_o  (queue_data),
    .empty_o (queue_empty)
  );

  assign queue_cmd = ssed_pkg::cmd_t'(queue_data);

  ssed_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (!queue_empty),
    .cmd_i            (queue_cmd),
    .cmd_pop_o        (queue_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .event_kind_o     (event_kind_o),
    .channel_o        (channel_o),
    .note_number_o    (note_number_o),
    .velocity_o       (velocity_o),
    .wheel_value_o    (wheel_value_o),
    .frames_o         (frames_o),
    .restart_o        (restart_o),
    .restart_offset_o (restart_offset_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

// File: rtl/ssed_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// A small first-in first-out queue of fixed-width words between the parser
// and the back end.
// ----------------------------------------------------------------------------
module ssed_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ssed_front.sv
// ----------------------------------------------------------------------------
// Song stream parser
// Takes song bytes, gathers lead and operand bytes and issues one command
// per byte that completes an event, ends the song, or both.
// ----------------------------------------------------------------------------
module ssed_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ssed_pkg::ByteW-1:0]   song_byte_i,
  input  logic                         start_of_pass_i,
  input  logic                         final_byte_i,
  output logic                         cmd_push_o,
  output ssed_pkg::cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_OP1  = 2'd1,
    PH_OP2  = 2'd2
  } phase_e;

  phase_e                       phase_q, phase_d, phase_cur;
  logic [ssed_pkg::ByteW-1:0]   lead_q, lead_d;
  logic [ssed_pkg::ByteW-1:0]   oper_q, oper_d;
  logic                         disc_q, disc_d, disc_cur;
  logic                         evt, end_res;
  ssed_pkg::cmd_t               cmd;
  logic [ssed_pkg::ByteW-1:0]   b;

  assign b = song_byte_i;

  always_comb begin
    phase_d   = phase_q;
    lead_d    = lead_q;
    oper_d    = oper_q;
    disc_d    = disc_q;
    evt       = 1'b0;
    end_res   = 1'b0;
    cmd       = '0;
    phase_cur = start_of_pass_i ? PH_LEAD : phase_q;
    disc_cur  = start_of_pass_i ? 1'b0 : disc_q;
    if (start_of_pass_i) begin
      phase_d = PH_LEAD;
      disc_d  = 1'b0;
    end
    if (!disc_cur) begin
      case (phase_cur)
        PH_OP1: begin
          phase_d = PH_LEAD;
          if (lead_q[7:4] == ssed_pkg::LeadTimedNote) begin
            oper_d  = b;
            phase_d = PH_OP2;
          end else if (lead_q[7:4] == ssed_pkg::LeadFireNote) begin
            evt          = 1'b1;
            cmd.kind     = ssed_pkg::KIND_FIRE;
            cmd.channel  = {lead_q[1:0], b[7]};
            cmd.note     = b[6:0];
            cmd.velocity = {1'b0, lead_q[3:2], lead_q[3:2], lead_q[3:2]};
          end else begin
            evt         = 1'b1;
            cmd.kind    = ssed_pkg::KIND_WHEEL;
            cmd.channel = lead_q[2:0];
            cmd.wheel   = b;
          end
        end
        PH_OP2: begin
          phase_d      = PH_LEAD;
          evt          = 1'b1;
          cmd.kind     = ssed_pkg::KIND_TIMED;
          cmd.channel  = oper_q[7:5];
          cmd.note     = {oper_q[4:0], b[7:6]};
          cmd.velocity = {lead_q[3:0], lead_q[3:1]};
          cmd.ms       = {b[5:0], 5'b0};
        end
        default: begin
          phase_d = PH_LEAD;
          if (b == '0) begin
            end_res = 1'b1;
          end else if (!b[7]) begin
            evt      = 1'b1;
            cmd.kind = ssed_pkg::KIND_DELAY;
            cmd.ms   = {4'b0, b[6:0]};
          end else if ((b[7:4] == ssed_pkg::LeadTimedNote) ||
                       (b[7:4] == ssed_pkg::LeadFireNote) ||
                       (b[7:3] == ssed_pkg::LeadWheel)) begin
            lead_d  = b;
            phase_d = PH_OP1;
          end else begin
            end_res = 1'b1;
          end
        end
      endcase
      if (final_byte_i) begin
        end_res = 1'b1;
      end
      if (end_res) begin
        disc_d  = 1'b1;
        phase_d = PH_LEAD;
      end
    end
    cmd.evt_valid = evt;
    cmd.end_flag  = end_res;
  end

  assign cmd_push_o = accept_i && (evt || end_res);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      lead_q  <= '0;
      oper_q  <= '0;
      disc_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      oper_q  <= oper_d;
      disc_q  <= disc_d;
    end
  end

endmodule

// File: rtl/ssed_back.sv
// ----------------------------------------------------------------------------
// Event back end
// Converts durations to frames with a registered multiply and presents each
// command as one or two result items in an output register.
// ----------------------------------------------------------------------------
module ssed_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssed_pkg::cfg_t                 cfg_i,
  input  logic                           cmd_valid_i,
  input  ssed_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [2:0]                     event_kind_o,
  output logic [ssed_pkg::ChanW-1:0]     channel_o,
  output logic [ssed_pkg::NoteW-1:0]     note_number_o,
  output logic [ssed_pkg::VelW-1:0]      velocity_o,
  output logic [ssed_pkg::ByteW-1:0]     wheel_value_o,
  output logic [ssed_pkg::FramesW-1:0]   frames_o,
  output logic                           restart_o,
  output logic [ssed_pkg::OffsetW-1:0]   restart_offset_o,
  output logic                           last_of_run_o
);

  localparam int unsigned WholeW = ssed_pkg::ProdW - ssed_pkg::FracW;

  logic                                 a_valid_q;
  ssed_pkg::cmd_t                       a_cmd_q;
  logic [ssed_pkg::ProdW-1:0]           a_prod_q;
  logic                                 b_valid_q;
  ssed_pkg::cmd_t                       b_cmd_q;
  logic [ssed_pkg::FramesW-1:0]         b_frames_q;
  logic                                 b_on_end_q;
  logic [ssed_pkg::FramesW-1:0]         frames_d;
  logic [WholeW-1:0]                    whole;
  logic                                 b_last, b_take, a_take;

  assign b_last    = b_on_end_q || !b_cmd_q.end_flag;
  assign b_take    = !b_valid_q || (pop_i && b_last);
  assign a_take    = !a_valid_q || b_take;
  assign cmd_pop_o = a_take && cmd_valid_i;
  assign whole     = a_prod_q[ssed_pkg::ProdW-1:ssed_pkg::FracW];

  // A nonzero duration never rounds down to zero frames.
  always_comb begin
    if (a_cmd_q.ms == '0) begin
      frames_d = '0;
    end else if (whole == '0) begin
      frames_d = ssed_pkg::FramesW'(1);
    end else begin
      frames_d = ssed_pkg::FramesW'(whole);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      b_on_end_q <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_q <= cmd_valid_i;
      end
      if (b_take) begin
        b_valid_q  <= a_valid_q;
        b_on_end_q <= !a_cmd_q.evt_valid;
      end else if (pop_i && b_valid_q) begin
        b_on_end_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      a_cmd_q  <= cmd_i;
      a_prod_q <= ssed_pkg::ProdW'(cmd_i.ms) * ssed_pkg::ProdW'(cfg_i.frame_rate);
    end
    if (b_take && a_valid_q) begin
      b_cmd_q    <= a_cmd_q;
      b_frames_q <= frames_d;
    end
  end

  always_comb begin
    empty_o       = !b_valid_q;
    last_of_run_o = b_last;
    if (b_on_end_q) begin
      event_kind_o     = ssed_pkg::KIND_END;
      channel_o        = '0;
      note_number_o    = '0;
      velocity_o       = '0;
      wheel_value_o    = '0;
      frames_o         = ssed_pkg::FramesW'(cfg_i.repeat_enable);
      restart_o        = cfg_i.repeat_enable;
      restart_offset_o = cfg_i.repeat_enable ? cfg_i.loop_offset : '0;
    end else begin
      event_kind_o     = b_cmd_q.kind;
      channel_o        = b_cmd_q.channel;
      note_number_o    = b_cmd_q.note;
      velocity_o       = b_cmd_q.velocity;
      wheel_value_o    = b_cmd_q.wheel;
      frames_o         = b_frames_q;
      restart_o        = 1'b0;
      restart_offset_o = '0;
    end
  end

endmodule
